FILE: rtl/bdlp_pkg.sv
// ----------------------------------------------------------------------------
// bdlp_pkg
// Types and constants shared by the button debounce and long-press block.
// ----------------------------------------------------------------------------
package bdlp_pkg;

  localparam int unsigned PinW   = 32;
  localparam int unsigned CountW = 6;
  localparam int unsigned TickW  = 8;
  localparam int unsigned CodeW  = 7;
  localparam int unsigned IdxW   = 5;

  // input item kinds
  localparam logic ActTick   = 1'b0;
  localparam logic ActSample = 1'b1;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_BUTTON_COUNT    = 2'd0,
    CFG_DEBOUNCE_TICKS  = 2'd1,
    CFG_LONG_TICKS      = 2'd2,
    CFG_UNUSED          = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } seq_state_e;

  typedef struct packed {
    logic            action;
    logic [PinW-1:0] pin_levels;
  } in_item_t;

  typedef struct packed {
    logic [CodeW-1:0] event_code;
    logic             last_event;
  } out_item_t;

  // one button's stored state
  typedef struct packed {
    logic             pressed;
    logic [TickW-1:0] debounce;
    logic [TickW-1:0] hold;
  } entry_t;

endpackage

FILE: rtl/button_debounce_long_press_events_top.sv
// ----------------------------------------------------------------------------
// button_debounce_long_press_events_top
// Debouncer with press, release and long-press events for a button bank.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_stall_o) takes one item: a pin level sample
// (action 1) or a time tick (action 0). Output channel (out_valid_o /
// out_stall_i) gives one item per event, last_event marking the final event
// of a tick; a sample gives none. Configuration registers are to be written
// on the cfg channel (always ready) while the block is idle; the block itself
// does not enforce this. Each item sweeps the per-button state memory once
// through its registered read, one button per cycle unless a receiver stall
// pauses the sweep as told below. in_stall_o stays high for the sweep.
// Events are held one deep so the last one can be flagged; if the receiver
// stalls while an event waits in the output register, the sweep or the
// final flush pauses.
// Reset clears the registers to button_count 32, debounce_ticks 2,
// long_press_ticks 50; per-button state reads as released and idle through
// per-entry valid bits, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module button_debounce_long_press_events_top
  import bdlp_pkg::*;
#(
  parameter int unsigned MAX_BUTTONS = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  in_item_t         in_item_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output out_item_t        out_item_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  cfg_idx_e         cfg_index_i,
  input  logic [TickW-1:0] cfg_data_i
);

  localparam int unsigned AW = (MAX_BUTTONS > 1) ? $clog2(MAX_BUTTONS) : 1;
  localparam logic [CountW-1:0] MaxCount = CountW'(MAX_BUTTONS);

  // configuration
  logic [CountW-1:0] button_count_q;
  logic [TickW-1:0]  debounce_ticks_q, long_ticks_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      button_count_q   <= CountW'(32);
      debounce_ticks_q <= TickW'(2);
      long_ticks_q     <= TickW'(50);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_BUTTON_COUNT:   button_count_q   <= cfg_data_i[CountW-1:0];
        CFG_DEBOUNCE_TICKS: debounce_ticks_q <= cfg_data_i;
        CFG_LONG_TICKS:     long_ticks_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // sequencer state
  seq_state_e        state_q, state_d;
  logic              action_q;
  logic [PinW-1:0]   pins_q;
  logic [CountW-1:0] lim_q, lim_d;
  logic [CountW-1:0] idx_q, idx_d;
  logic              p_v_q, p_v_d;
  logic [CountW-1:0] p_idx_q, p_idx_d;
  logic              pend_v_q, pend_v_d;
  logic [CodeW-1:0]  pend_code_q, pend_code_d;
  logic              out_v_q, out_v_d;
  out_item_t         out_q, out_d;
  logic              in_accept;

  // memory and update wiring
  logic              re, we;
  entry_t            rdata, wdata;
  logic              emit;
  logic [CodeW-1:0]  code;
  logic [TickW-1:0]  reload;

  assign reload    = (debounce_ticks_q == '0) ? TickW'(1) : debounce_ticks_q;
  assign lim_d     = (button_count_q > MaxCount) ? MaxCount : button_count_q;
  assign in_accept = in_valid_i && !in_stall_o;

  bdlp_state_mem #(
    .DEPTH (MAX_BUTTONS),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .re_i    (re),
    .raddr_i (idx_q[AW-1:0]),
    .rdata_o (rdata),
    .we_i    (we),
    .waddr_i (p_idx_q[AW-1:0]),
    .wdata_i (wdata)
  );

  bdlp_button_update u_upd (
    .cur_i        (rdata),
    .action_i     (action_q),
    .pin_i        (pins_q[p_idx_q[AW-1:0]]),
    .idx_i        (p_idx_q[IdxW-1:0]),
    .reload_i     (reload),
    .long_ticks_i (long_ticks_q),
    .nxt_o        (wdata),
    .emit_o       (emit),
    .code_o       (code)
  );

  always_comb begin
    logic out_free, emit_v, adv;
    out_free    = !out_v_q || !out_stall_i;
    emit_v      = p_v_q && emit;
    adv         = !(emit_v && pend_v_q && !out_free);
    state_d     = state_q;
    idx_d       = idx_q;
    p_v_d       = p_v_q;
    p_idx_d     = p_idx_q;
    pend_v_d    = pend_v_q;
    pend_code_d = pend_code_q;
    out_v_d     = out_v_q && out_stall_i;
    out_d       = out_q;
    re          = 1'b0;
    we          = 1'b0;
    in_stall_o  = (state_q != ST_IDLE);

    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          idx_d   = '0;
          p_v_d   = 1'b0;
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!p_v_q && idx_q >= lim_q) begin
          state_d = ST_FLUSH;
        end else if (adv) begin
          if (p_v_q) begin
            we = 1'b1;
            if (emit_v) begin
              // older event goes out, newest one waits for the next
              if (pend_v_q) begin
                out_v_d          = 1'b1;
                out_d.event_code = pend_code_q;
                out_d.last_event = 1'b0;
              end
              pend_v_d    = 1'b1;
              pend_code_d = code;
            end
          end
          if (idx_q < lim_q) begin
            re      = 1'b1;
            p_v_d   = 1'b1;
            p_idx_d = idx_q;
            idx_d   = idx_q + CountW'(1);
          end else begin
            p_v_d = 1'b0;
          end
        end
      end
      ST_FLUSH: begin
        if (!pend_v_q) begin
          state_d = ST_IDLE;
        end else if (out_free) begin
          out_v_d          = 1'b1;
          out_d.event_code = pend_code_q;
          out_d.last_event = 1'b1;
          pend_v_d         = 1'b0;
          state_d          = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      idx_q    <= '0;
      p_v_q    <= 1'b0;
      p_idx_q  <= '0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      p_v_q    <= p_v_d;
      p_idx_q  <= p_idx_d;
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_code_q <= pend_code_d;
    out_q       <= out_d;
    if (in_accept) begin
      action_q <= in_item_i.action;
      pins_q   <= in_item_i.pin_levels;
      lim_q    <= lim_d;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_item_o  = out_q;

endmodule

FILE: rtl/bdlp_state_mem.sv
// ----------------------------------------------------------------------------
// bdlp_state_mem
// Per-button state memory, one write and one registered read per cycle.
// Entries never written since reset read as zero.
// ----------------------------------------------------------------------------
module bdlp_state_mem
  import bdlp_pkg::*;
#(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = 5
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output entry_t        rdata_o,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  entry_t        wdata_i
);

  entry_t           mem_q [DEPTH];
  logic [DEPTH-1:0] vld_q;
  entry_t           rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (we_i) begin
      vld_q[waddr_i] <= 1'b1;
    end
  end

  // read data holds while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= vld_q[raddr_i] ? mem_q[raddr_i] : '0;
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/bdlp_button_update.sv
// ----------------------------------------------------------------------------
// bdlp_button_update
// Next state and event of one button for a sample or a tick.
// ----------------------------------------------------------------------------
module bdlp_button_update
  import bdlp_pkg::*;
(
  input  entry_t           cur_i,
  input  logic             action_i,
  input  logic             pin_i,
  input  logic [IdxW-1:0]  idx_i,
  input  logic [TickW-1:0] reload_i,
  input  logic [TickW-1:0] long_ticks_i,
  output entry_t           nxt_o,
  output logic             emit_o,
  output logic [CodeW-1:0] code_o
);

  logic now_pressed;

  assign now_pressed = ~pin_i;

  always_comb begin
    nxt_o  = cur_i;
    emit_o = 1'b0;
    code_o = {2'b00, idx_i};
    if (action_i == ActSample) begin
      if (now_pressed != cur_i.pressed) begin
        nxt_o.pressed  = now_pressed;
        nxt_o.debounce = reload_i;
      end
    end else begin
      if (cur_i.debounce != '0) begin
        nxt_o.debounce = cur_i.debounce - TickW'(1);
        if (nxt_o.debounce == '0) begin
          emit_o = 1'b1;
          if (cur_i.pressed) begin
            nxt_o.hold = long_ticks_i;
            code_o     = {2'b00, idx_i};
          end else begin
            // long flag when the hold timer had already run out
            code_o     = {1'b1, (cur_i.hold == '0) && (long_ticks_i != '0), idx_i};
            nxt_o.hold = '0;
          end
        end
      end
      if (!emit_o && cur_i.hold != '0) begin
        nxt_o.hold = cur_i.hold - TickW'(1);
        if (nxt_o.hold == '0) begin
          emit_o = 1'b1;
          code_o = {2'b01, idx_i};
        end
      end
    end
  end

endmodule

FILE: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Checks the button debounce and long-press block against a cycle-free model
// of its per-button state. A directed table covers reset values, press,
// release, long-press and the register corner cases; random phases under
// several register settings follow, with random gaps and stalls on both
// channels and one long receiver hold-off that backs the block up.
// ----------------------------------------------------------------------------
module tb_top;
  import bdlp_pkg::*;

  localparam logic [CodeW-1:0] EvRelease = 7'h40;
  localparam logic [CodeW-1:0] EvLong    = 7'h20;
  localparam int unsigned      SweepWait = 48;      // one full sweep plus margin
  localparam int unsigned      CycleLimit = 800000;
  localparam int unsigned      RandPhases = 10;
  localparam int unsigned      PhaseItems = 39;
  localparam int unsigned      HoldOffCycles = 300;

  typedef enum logic {RowItem, RowReg} row_kind_e;

  typedef struct packed {
    row_kind_e        kind;
    cfg_idx_e         reg_idx;
    logic [TickW-1:0] reg_val;
    logic             action;
    logic [PinW-1:0]  pins;
    logic             typed;     // expected events written out below
    logic [1:0]       n_want;
    logic [CodeW-1:0] want_a;
    logic [CodeW-1:0] want_b;
  } dir_row_t;

  localparam int unsigned NumRows = 29;
  localparam dir_row_t DIRECTED [NumRows] = '{
    // reset settings: 32 buttons, debounce 2, long 50
    '{RowItem, CFG_UNUSED, 8'd0, ActTick,   32'hFFFF_FFFF, 1'b1, 2'd0, 7'd0, 7'd0},
    '{RowItem, CFG_UNUSED, 8'd0, ActSample, 32'hFFFF_FFFF, 1'b1, 2'd0, 7'd0, 7'd0},
    '{RowItem, CFG_UNUSED, 8'd0, ActSample, 32'h7FFF_FFFE, 1'b1, 2'd0, 7'd0, 7'd0},
    '{RowItem, CFG_UNUSED, 8'd0, ActTick,   32'h0000_0000, 1'b1, 2'd0, 7'd0, 7'd0},
    '{RowItem, CFG_UNUSED, 8'd0, ActTick,   32'h0000_0000, 1'b1, 2'd2, 7'd0, 7'd31},
    '{RowItem, CFG_UNUSED, 8'd0, ActSample, 32'hFFFF_FFFF, 1'b1, 2'd0, 7'd0, 7'd0},
    '{RowItem, CFG_UNUSED, 8'd0, ActTick,   32'h0000_0000, 1'b1, 2'd0, 7'd0, 7'd0},
    // released before the hold timer ran out: no long flag
    '{RowItem, CFG_UNUSED, 8'd0, ActTick,   32'h0000_0000, 1'b1, 2'd2,
      EvRelease, EvRelease | 7'd31},
    // short hold timer, zero debounce acts as one
    '{RowReg, CFG_LONG_TICKS,     8'd2, ActTick, 32'h0, 1'b0, 2'd0, 7'd0, 7'd0},
    '{RowReg, CFG_DEBOUNCE_TICKS, 8'd0, ActTick, 32'h0, 1'b0, 2'd0, 7'd0, 7'd0},
    '{RowItem, CFG_UNUSED, 8'd0, ActSample, 32'hFFFF_FFFB, 1'b1, 2'd0, 7'd0, 7'd0},
    '{RowItem, CFG_UNUSED, 8'd0, ActTick,   32'h0000_0000, 1'b1, 2'd1, 7'd2, 7'd0},
    // hold timer does not move on the press tick
    '{RowItem, CFG_UNUSED, 8'd0, ActTick,   32'h0000_0000, 1'b1, 2'd0, 7'd0, 7'd0},
    '{RowItem, CFG_UNUSED, 8'd0, ActTick,   32'h0000_0000, 1'b1, 2'd1, EvLong | 7'd2, 7'd0},
    '{RowItem, CFG_UNUSED, 8'd0, ActSample, 32'hFFFF_FFFF, 1'b1, 2'd0, 7'd0, 7'd0},
    '{RowItem, CFG_UNUSED, 8'd0, ActTick,   32'h0000_0000, 1'b1, 2'd1,
      EvRelease | EvLong | 7'd2, 7'd0},
    // timer off, count above the bank size
    '{RowReg, CFG_LONG_TICKS,   8'd0,  ActTick, 32'h0, 1'b0, 2'd0, 7'd0, 7'd0},
    '{RowReg, CFG_BUTTON_COUNT, 8'd40, ActTick, 32'h0, 1'b0, 2'd0, 7'd0, 7'd0},
    '{RowItem, CFG_UNUSED, 8'd0, ActSample, 32'h0000_0000, 1'b1, 2'd0, 7'd0, 7'd0},
    '{RowItem, CFG_UNUSED, 8'd0, ActTick,   32'h0000_0000, 1'b0, 2'd0, 7'd0, 7'd0},
    '{RowItem, CFG_UNUSED, 8'd0, ActTick,   32'h0000_0000, 1'b1, 2'd0, 7'd0, 7'd0},
    '{RowItem, CFG_UNUSED, 8'd0, ActSample, 32'hFFFF_FFFF, 1'b1, 2'd0, 7'd0, 7'd0},
    '{RowItem, CFG_UNUSED, 8'd0, ActTick,   32'h0000_0000, 1'b0, 2'd0, 7'd0, 7'd0},
    // no button in use, then one, with the widest timers
    '{RowReg, CFG_BUTTON_COUNT,   8'd0,   ActTick, 32'h0, 1'b0, 2'd0, 7'd0, 7'd0},
    '{RowReg, CFG_DEBOUNCE_TICKS, 8'd255, ActTick, 32'h0, 1'b0, 2'd0, 7'd0, 7'd0},
    '{RowReg, CFG_LONG_TICKS,     8'd255, ActTick, 32'h0, 1'b0, 2'd0, 7'd0, 7'd0},
    '{RowItem, CFG_UNUSED, 8'd0, ActSample, 32'h0000_0000, 1'b1, 2'd0, 7'd0, 7'd0},
    '{RowItem, CFG_UNUSED, 8'd0, ActTick,   32'h0000_0000, 1'b1, 2'd0, 7'd0, 7'd0},
    '{RowReg, CFG_BUTTON_COUNT,   8'd1,   ActTick, 32'h0, 1'b0, 2'd0, 7'd0, 7'd0}
  };

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_item_t  in_item_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_item_t out_item_o;
  logic      cfg_valid_i;
  logic      cfg_ready_o;
  cfg_idx_e  cfg_index_i;
  logic [TickW-1:0] cfg_data_i;

  // model of the bank
  logic [CountW-1:0] live_count;
  logic [TickW-1:0]  settle_ticks;
  logic [TickW-1:0]  long_ticks;
  logic              btn_down   [32];
  logic [TickW-1:0]  settle_left [32];
  logic [TickW-1:0]  hold_left  [32];

  out_item_t   tick_events [$];
  out_item_t   pending_events [$];
  int unsigned mismatches;
  int unsigned cycles;
  bit          quiet_mode;
  bit          hold_off_req;

  button_debounce_long_press_events_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("button_debounce_long_press_events_top regression: fail");
      $finish;
    end
  end

  function automatic int unsigned buttons_live();
    return (live_count > 6'd32) ? 32 : int'(live_count);
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycles, msg);
    mismatches++;
  endtask

  task automatic predict_item(input in_item_t it);
    int unsigned      n;
    logic [TickW-1:0] reload;
    logic             now;
    logic             fired;
    logic [CodeW-1:0] code;
    out_item_t        ev;
    n = buttons_live();
    tick_events.delete();
    if (it.action == ActSample) begin
      reload = (settle_ticks == 0) ? 8'd1 : settle_ticks;
      for (int i = 0; i < n; i++) begin
        now = ~it.pin_levels[i];
        if (now != btn_down[i]) begin
          btn_down[i]    = now;
          settle_left[i] = reload;
        end
      end
    end else begin
      for (int i = 0; i < n; i++) begin
        fired = 1'b0;
        code  = '0;
        if (settle_left[i] != 0) begin
          settle_left[i]--;
          if (settle_left[i] == 0) begin
            fired = 1'b1;
            if (btn_down[i]) begin
              hold_left[i] = long_ticks;
              code = 7'(i);
            end else begin
              code = EvRelease | 7'(i);
              if (hold_left[i] == 0 && long_ticks != 0) code |= EvLong;
              hold_left[i] = '0;
            end
          end
        end
        if (!fired && hold_left[i] != 0) begin
          hold_left[i]--;
          if (hold_left[i] == 0) begin
            fired = 1'b1;
            code  = EvLong | 7'(i);
          end
        end
        if (fired) begin
          ev.event_code = code;
          ev.last_event = 1'b0;
          tick_events.push_back(ev);
        end
      end
      if (tick_events.size() > 0) begin
        ev = tick_events.pop_back();
        ev.last_event = 1'b1;
        tick_events.push_back(ev);
      end
    end
  endtask

  // offers one item, returns at the edge that takes it
  task automatic send_item(input in_item_t it, input bit use_model);
    if (!quiet_mode && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    predict_item(it);
    if (use_model) begin
      foreach (tick_events[k]) pending_events.push_back(tick_events[k]);
    end
  endtask

  task automatic drain_and_settle();
    in_valid_i <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (SweepWait) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [TickW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_BUTTON_COUNT:   live_count   = val[CountW-1:0];
      CFG_DEBOUNCE_TICKS: settle_ticks = val;
      CFG_LONG_TICKS:     long_ticks   = val;
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // result checker
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_events.size() == 0) begin
        flag_mismatch($sformatf("unexpected event code %h", out_item_o.event_code));
      end else begin
        want = pending_events.pop_front();
        if (out_item_o.event_code != want.event_code)
          flag_mismatch($sformatf("event_code %h, want %h",
                                  out_item_o.event_code, want.event_code));
        if (out_item_o.last_event != want.last_event)
          flag_mismatch($sformatf("last_event %b, want %b on code %h",
                                  out_item_o.last_event, want.last_event,
                                  want.event_code));
      end
    end
  end

  // receiver: random stalls, one long hold-off on request
  initial begin
    bit          stall_now;
    int unsigned span;
    out_stall_i = 1'b0;
    @(posedge clk_i);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall_now = 1'b1;
        span = HoldOffCycles;
      end else if (quiet_mode) begin
        stall_now = 1'b0;
        span = 1;
      end else begin
        stall_now = ($urandom_range(0, 3) == 0);
        span = $urandom_range(1, 10);
      end
      out_stall_i <= stall_now;
      repeat (span) @(posedge clk_i);
    end
  end

  // sender and register writes
  initial begin
    dir_row_t         row;
    in_item_t         item;
    out_item_t        ev;
    logic [PinW-1:0]  pin_img;
    logic [TickW-1:0] c_val;
    logic [TickW-1:0] d_val;
    logic [TickW-1:0] l_val;
    int unsigned      pick;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    in_item_i    = '0;
    cfg_valid_i  = 1'b0;
    cfg_index_i  = CFG_BUTTON_COUNT;
    cfg_data_i   = '0;
    cycles       = 0;
    mismatches   = 0;
    quiet_mode   = 1'b0;
    hold_off_req = 1'b0;
    live_count   = 6'd32;
    settle_ticks = 8'd2;
    long_ticks   = 8'd50;
    for (int i = 0; i < 32; i++) begin
      btn_down[i]    = 1'b0;
      settle_left[i] = '0;
      hold_left[i]   = '0;
    end
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (DIRECTED[r]) begin
      row = DIRECTED[r];
      if (row.kind == RowReg) begin
        drain_and_settle();
        write_reg(row.reg_idx, row.reg_val);
      end else begin
        item.action     = row.action;
        item.pin_levels = row.pins;
        send_item(item, !row.typed);
        if (row.typed) begin
          for (int k = 0; k < row.n_want; k++) begin
            ev.event_code = (k == 0) ? row.want_a : row.want_b;
            ev.last_event = (k == row.n_want - 1);
            pending_events.push_back(ev);
          end
        end
      end
    end

    pin_img = '1;
    for (int ph = 0; ph < RandPhases; ph++) begin
      drain_and_settle();
      case (ph)
        0: begin c_val = 8'd32; d_val = 8'd1; l_val = 8'd1; end
        1: begin c_val = 8'hFF; d_val = 8'd255; l_val = 8'd255; end
        3: begin c_val = 8'd32; d_val = 8'd1; l_val = 8'd3; end
        default: begin
          c_val = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(33, 63))
                                              : 8'($urandom_range(1, 32));
          d_val = 8'($urandom_range(0, 4));
          l_val = 8'($urandom_range(0, 6));
        end
      endcase
      write_reg(CFG_BUTTON_COUNT, c_val);
      write_reg(CFG_DEBOUNCE_TICKS, d_val);
      write_reg(CFG_LONG_TICKS, l_val);
      quiet_mode = (ph == RandPhases - 1);
      if (ph == 3) hold_off_req = 1'b1;
      for (int k = 0; k < PhaseItems; k++) begin
        pick = $urandom_range(0, 9);
        if (pick < 5) begin
          item.action     = ActTick;
          item.pin_levels = $urandom;
        end else begin
          // mostly a few buttons change, now and then the whole bank bounces
          if (pick < 8) begin
            repeat ($urandom_range(1, 3))
              pin_img[$urandom_range(0, buttons_live() - 1)] ^= 1'b1;
          end else if (pick == 8) begin
            pin_img = $urandom;
          end
          item.action     = ActSample;
          item.pin_levels = pin_img;
        end
        send_item(item, 1'b1);
      end
    end

    drain_and_settle();
    if (mismatches == 0) begin
      $display("button_debounce_long_press_events_top regression: pass");
    end else begin
      $display("button_debounce_long_press_events_top regression: fail");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/bdlp_pkg.sv
rtl/bdlp_state_mem.sv
rtl/bdlp_button_update.sv
rtl/button_debounce_long_press_events_top.sv
dv/tb_top.sv
